/* hdl/tlwd_pkg.sv */
// Shared types and constants for the weighted tree distance engine.
package tlwd_pkg;

  // Field widths of the item and result ports and of the stored depths.
  localparam int unsigned NODE_W   = 10;
  localparam int unsigned DEPTH_W  = 10;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned COST_W   = 26;

  // Default sizing.
  localparam int unsigned NODE_COUNT_DEF  = 1024;
  localparam int unsigned LIFT_LEVELS_DEF = 10;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  // One accepted input item, after out-of-range node numbers are folded to 0.
  typedef struct packed {
    cmd_e                cmd;
    logic [NODE_W-1:0]   node;
    logic [NODE_W-1:0]   parent_node;
    logic [WEIGHT_W-1:0] edge_weight;
    logic [NODE_W-1:0]   other_node;
  } item_t;

  // One lifting row entry: the 2^i-th ancestor and the cost of that climb.
  typedef struct packed {
    logic [NODE_W-1:0] anc;
    logic [COST_W-1:0] cost;
  } row_t;

  localparam int unsigned ROW_W = $bits(row_t);

endpackage

/* hdl/tlwd_ram.sv */
// Generic RAM: one write port, two registered read ports.
module tlwd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr0_i,
  input  logic [AW-1:0]    raddr1_i,
  output logic [WIDTH-1:0] rdata0_o,
  output logic [WIDTH-1:0] rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata0_q;
  logic [WIDTH-1:0] rdata1_q;

  // Write one entry.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Register both read ports.
  always_ff @(posedge clk_i) begin
    rdata0_q <= mem_q[raddr0_i];
    rdata1_q <= mem_q[raddr1_i];
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

/* hdl/tlwd_seq.sv */
// Sequencer and datapath: row fill on load, binary lifting on query.
module tlwd_seq #(
  parameter int unsigned NODE_COUNT  = tlwd_pkg::NODE_COUNT_DEF,
  parameter int unsigned LIFT_LEVELS = tlwd_pkg::LIFT_LEVELS_DEF,
  localparam int unsigned ROW_AW = $clog2(NODE_COUNT * LIFT_LEVELS),
  localparam int unsigned DEP_AW = $clog2(NODE_COUNT)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // item start
  input  logic                          start_i,
  input  tlwd_pkg::item_t               item_i,
  output logic                          idle_o,
  // row memory
  output logic                          row_we_o,
  output logic [ROW_AW-1:0]             row_waddr_o,
  output tlwd_pkg::row_t                row_wdata_o,
  output logic [ROW_AW-1:0]             row_raddr0_o,
  output logic [ROW_AW-1:0]             row_raddr1_o,
  input  tlwd_pkg::row_t                row_rdata0_i,
  input  tlwd_pkg::row_t                row_rdata1_i,
  // depth memory
  output logic                          dep_we_o,
  output logic [DEP_AW-1:0]             dep_waddr_o,
  output logic [tlwd_pkg::DEPTH_W-1:0]  dep_wdata_o,
  output logic [DEP_AW-1:0]             dep_raddr0_o,
  output logic [DEP_AW-1:0]             dep_raddr1_o,
  input  logic [tlwd_pkg::DEPTH_W-1:0]  dep_rdata0_i,
  input  logic [tlwd_pkg::DEPTH_W-1:0]  dep_rdata1_i,
  // result
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic [tlwd_pkg::COST_W-1:0]   res_o
);

  localparam int unsigned CNT_W = $clog2(LIFT_LEVELS + 1);
  localparam logic [CNT_W-1:0] LVL_TOP = CNT_W'(LIFT_LEVELS - 1);
  localparam logic [CNT_W-1:0] LVL_END = CNT_W'(LIFT_LEVELS);

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_LD_DEP  = 12'b0000_0000_0010,
    S_LD_RD   = 12'b0000_0000_0100,
    S_LD_WR   = 12'b0000_0000_1000,
    S_Q_DEP   = 12'b0000_0001_0000,
    S_LIFT    = 12'b0000_0010_0000,
    S_LIFT_WT = 12'b0000_0100_0000,
    S_J_RD    = 12'b0000_1000_0000,
    S_J_WT    = 12'b0001_0000_0000,
    S_FIN_RD  = 12'b0010_0000_0000,
    S_FIN_WT  = 12'b0100_0000_0000,
    S_DONE    = 12'b1000_0000_0000
  } state_e;

  function automatic logic [ROW_AW-1:0] row_addr(
    input logic [tlwd_pkg::NODE_W-1:0] n,
    input logic [CNT_W-1:0]            l
  );
    return ROW_AW'(32'(n) * 32'(LIFT_LEVELS) + 32'(l));
  endfunction

  state_e                          state_q, state_d;
  logic [tlwd_pkg::NODE_W-1:0]     a_q, a_d;
  logic [tlwd_pkg::NODE_W-1:0]     b_q, b_d;
  logic [tlwd_pkg::NODE_W-1:0]     par_q, par_d;
  logic [tlwd_pkg::WEIGHT_W-1:0]   wt_q, wt_d;
  tlwd_pkg::row_t                  cur_q, cur_d;
  logic [tlwd_pkg::COST_W-1:0]     acc_q, acc_d;
  logic [tlwd_pkg::DEPTH_W-1:0]    gap_q, gap_d;
  logic [CNT_W-1:0]                lvl_q, lvl_d;
  logic                            zf0_q, zf1_q;

  logic [tlwd_pkg::NODE_W-1:0]     rd0_node, rd1_node;
  logic [CNT_W-1:0]                rd0_lvl, rd1_lvl;
  tlwd_pkg::row_t                  row0, row1;
  logic [tlwd_pkg::DEPTH_W-1:0]    dep0, dep1;
  logic [tlwd_pkg::DEPTH_W-1:0]    gap_sh;
  tlwd_pkg::row_t                  new_row;

  // Mask reads of the node 0 sentinel to zero.
  assign row0 = zf0_q ? '0 : row_rdata0_i;
  assign row1 = zf1_q ? '0 : row_rdata1_i;
  assign dep0 = zf0_q ? '0 : dep_rdata0_i;
  assign dep1 = zf1_q ? '0 : dep_rdata1_i;

  assign gap_sh = gap_q >> lvl_q;

  assign row_raddr0_o = row_addr(rd0_node, rd0_lvl);
  assign row_raddr1_o = row_addr(rd1_node, rd1_lvl);
  assign dep_raddr0_o = DEP_AW'(rd0_node);
  assign dep_raddr1_o = DEP_AW'(rd1_node);

  assign idle_o      = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = acc_q;

  // Next state, memory accesses and datapath.
  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    b_d     = b_q;
    par_d   = par_q;
    wt_d    = wt_q;
    cur_d   = cur_q;
    acc_d   = acc_q;
    gap_d   = gap_q;
    lvl_d   = lvl_q;

    rd0_node = '0;
    rd1_node = '0;
    rd0_lvl  = '0;
    rd1_lvl  = '0;

    row_we_o    = 1'b0;
    row_waddr_o = row_addr(a_q, lvl_q);
    new_row     = '0;
    dep_we_o    = 1'b0;
    dep_waddr_o = DEP_AW'(a_q);
    dep_wdata_o = dep0 + tlwd_pkg::DEPTH_W'(1);

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          a_d   = item_i.node;
          b_d   = item_i.other_node;
          par_d = item_i.parent_node;
          wt_d  = item_i.edge_weight;
          if (item_i.cmd == tlwd_pkg::CMD_LOAD) begin
            // read the parent's depth; a load of node 0 is dropped
            rd0_node = item_i.parent_node;
            if (item_i.node != '0) begin
              state_d = S_LD_DEP;
            end
          end else begin
            rd0_node = item_i.node;
            rd1_node = item_i.other_node;
            state_d  = S_Q_DEP;
          end
        end
      end

      S_LD_DEP: begin
        // store depth and level 0 row
        dep_we_o     = 1'b1;
        new_row.anc  = par_q;
        new_row.cost = (par_q == '0) ? '0 : tlwd_pkg::COST_W'(wt_q);
        row_we_o     = 1'b1;
        row_waddr_o  = row_addr(a_q, '0);
        cur_d        = new_row;
        lvl_d        = CNT_W'(1);
        state_d      = (LIFT_LEVELS == 1) ? S_IDLE : S_LD_RD;
      end

      S_LD_RD: begin
        rd0_node = cur_q.anc;
        rd0_lvl  = lvl_q - CNT_W'(1);
        state_d  = S_LD_WR;
      end

      S_LD_WR: begin
        // combine own row with the midpoint's row
        new_row.anc  = row0.anc;
        new_row.cost = row0.cost + cur_q.cost;
        row_we_o     = 1'b1;
        row_waddr_o  = row_addr(a_q, lvl_q);
        cur_d        = new_row;
        lvl_d        = lvl_q + CNT_W'(1);
        state_d      = (lvl_q == LVL_TOP) ? S_IDLE : S_LD_RD;
      end

      S_Q_DEP: begin
        // order so that b is the deeper node
        if (dep0 > dep1) begin
          a_d   = b_q;
          b_d   = a_q;
          gap_d = dep0 - dep1;
        end else begin
          gap_d = dep1 - dep0;
        end
        acc_d   = '0;
        lvl_d   = '0;
        state_d = S_LIFT;
      end

      S_LIFT: begin
        if (lvl_q == LVL_END) begin
          lvl_d   = LVL_TOP;
          state_d = (a_q == b_q) ? S_DONE : S_J_RD;
        end else if (gap_sh[0]) begin
          rd1_node = b_q;
          rd1_lvl  = lvl_q;
          state_d  = S_LIFT_WT;
        end else begin
          lvl_d = lvl_q + CNT_W'(1);
        end
      end

      S_LIFT_WT: begin
        acc_d   = acc_q + row1.cost;
        b_d     = row1.anc;
        lvl_d   = lvl_q + CNT_W'(1);
        state_d = S_LIFT;
      end

      S_J_RD: begin
        if (a_q == b_q) begin
          state_d = S_FIN_RD;
        end else begin
          rd0_node = a_q;
          rd1_node = b_q;
          rd0_lvl  = lvl_q;
          rd1_lvl  = lvl_q;
          state_d  = S_J_WT;
        end
      end

      S_J_WT: begin
        // climb both while their ancestors differ
        if (row0.anc != row1.anc) begin
          acc_d = acc_q + row0.cost + row1.cost;
          a_d   = row0.anc;
          b_d   = row1.anc;
        end
        if (lvl_q == '0) begin
          state_d = S_FIN_RD;
        end else begin
          lvl_d   = lvl_q - CNT_W'(1);
          state_d = S_J_RD;
        end
      end

      S_FIN_RD: begin
        rd0_node = a_q;
        rd1_node = b_q;
        state_d  = S_FIN_WT;
      end

      S_FIN_WT: begin
        // add the last edge on each side
        acc_d   = acc_q + row0.cost + row1.cost;
        state_d = S_DONE;
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign row_wdata_o = new_row;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Payload registers and sentinel flags for the reads in flight.
  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    par_q <= par_d;
    wt_q  <= wt_d;
    cur_q <= cur_d;
    acc_q <= acc_d;
    gap_q <= gap_d;
    lvl_q <= lvl_d;
    zf0_q <= (rd0_node == '0);
    zf1_q <= (rd1_node == '0);
  end

endmodule

/* hdl/tree_lca_weighted_distance.sv */
// Top level: weighted tree path length engine with binary lifting tables.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+------------------------------------
//   in      | input     | in_valid_i / in_stall_o   | cmd, node, parent_node,
//           |           |                           | edge_weight, other_node
//   out     | output    | out_valid_o / out_stall_i | path_length
//
// Load: parent depth read on accept, then the depth and the level 0 row written together,
// then one row read and one row write for each higher level.
// Query: depth reads on accept and their compare, then the deeper node lifted level by level,
// a joint pass from the top level down, the last edge on each side added, and hand-off.
// Reset clears the control state only; memories are not cleared, and node 0 reads as zero.
// A result waits in the output register while the next item is taken; a full, stalled
// output register holds the engine in its result state.
module tree_lca_weighted_distance #(
  parameter int unsigned NODE_COUNT  = tlwd_pkg::NODE_COUNT_DEF,
  parameter int unsigned LIFT_LEVELS = tlwd_pkg::LIFT_LEVELS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           cmd_i,
  input  logic [tlwd_pkg::NODE_W-1:0]    node_i,
  input  logic [tlwd_pkg::NODE_W-1:0]    parent_node_i,
  input  logic [tlwd_pkg::WEIGHT_W-1:0]  edge_weight_i,
  input  logic [tlwd_pkg::NODE_W-1:0]    other_node_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [tlwd_pkg::COST_W-1:0]    path_length_o
);

  localparam int unsigned ROW_DEPTH = NODE_COUNT * LIFT_LEVELS;
  localparam int unsigned ROW_AW    = $clog2(ROW_DEPTH);
  localparam int unsigned DEP_AW    = $clog2(NODE_COUNT);

  tlwd_pkg::item_t                item;
  logic                           idle;
  logic                           accept;

  logic                           row_we;
  logic [ROW_AW-1:0]              row_waddr, row_raddr0, row_raddr1;
  tlwd_pkg::row_t                 row_wdata, row_rdata0, row_rdata1;
  logic                           dep_we;
  logic [DEP_AW-1:0]              dep_waddr, dep_raddr0, dep_raddr1;
  logic [tlwd_pkg::DEPTH_W-1:0]   dep_wdata, dep_rdata0, dep_rdata1;

  logic                           res_valid;
  logic                           res_ready;
  logic [tlwd_pkg::COST_W-1:0]    res;

  logic                           out_valid_q;
  logic [tlwd_pkg::COST_W-1:0]    path_q;

  // Fold node numbers beyond the table to the sentinel.
  function automatic logic [tlwd_pkg::NODE_W-1:0] fold(
    input logic [tlwd_pkg::NODE_W-1:0] n
  );
    return (32'(n) < NODE_COUNT) ? n : '0;
  endfunction

  always_comb begin
    item.cmd         = tlwd_pkg::cmd_e'(cmd_i);
    item.node        = fold(node_i);
    item.parent_node = fold(parent_node_i);
    item.edge_weight = edge_weight_i;
    item.other_node  = fold(other_node_i);
  end

  assign in_stall_o = !idle;
  assign accept     = in_valid_i && !in_stall_o;

  tlwd_seq #(
    .NODE_COUNT  (NODE_COUNT),
    .LIFT_LEVELS (LIFT_LEVELS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (accept),
    .item_i       (item),
    .idle_o       (idle),
    .row_we_o     (row_we),
    .row_waddr_o  (row_waddr),
    .row_wdata_o  (row_wdata),
    .row_raddr0_o (row_raddr0),
    .row_raddr1_o (row_raddr1),
    .row_rdata0_i (row_rdata0),
    .row_rdata1_i (row_rdata1),
    .dep_we_o     (dep_we),
    .dep_waddr_o  (dep_waddr),
    .dep_wdata_o  (dep_wdata),
    .dep_raddr0_o (dep_raddr0),
    .dep_raddr1_o (dep_raddr1),
    .dep_rdata0_i (dep_rdata0),
    .dep_rdata1_i (dep_rdata1),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  // Ancestor and climb cost rows, one entry per node and level.
  tlwd_ram #(
    .WIDTH (tlwd_pkg::ROW_W),
    .DEPTH (ROW_DEPTH)
  ) u_row_ram (
    .clk_i    (clk_i),
    .we_i     (row_we),
    .waddr_i  (row_waddr),
    .wdata_i  (row_wdata),
    .raddr0_i (row_raddr0),
    .raddr1_i (row_raddr1),
    .rdata0_o (row_rdata0),
    .rdata1_o (row_rdata1)
  );

  // Node depths.
  tlwd_ram #(
    .WIDTH (tlwd_pkg::DEPTH_W),
    .DEPTH (NODE_COUNT)
  ) u_dep_ram (
    .clk_i    (clk_i),
    .we_i     (dep_we),
    .waddr_i  (dep_waddr),
    .wdata_i  (dep_wdata),
    .raddr0_i (dep_raddr0),
    .raddr1_i (dep_raddr1),
    .rdata0_o (dep_rdata0),
    .rdata1_o (dep_rdata1)
  );

  // Output register: take a result when empty or being drained.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      path_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign path_length_o = path_q;

endmodule

/* sim/tree_lca_weighted_distance_tb.sv */
// Self-checking testbench for the weighted tree distance engine.
module tree_lca_weighted_distance_tb;
  import tlwd_pkg::*;

  typedef logic [NODE_W-1:0]   node_t;
  typedef logic [DEPTH_W-1:0]  depth_t;
  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [COST_W-1:0]   cost_t;

  // Mirror of the lifting tables; predicts the path length of each query.
  class path_scoreboard;
    node_t  anc_row  [NODE_COUNT_DEF][LIFT_LEVELS_DEF];
    cost_t  cost_row [NODE_COUNT_DEF][LIFT_LEVELS_DEF];
    depth_t depth_of [NODE_COUNT_DEF];
    bit     loaded   [NODE_COUNT_DEF];
    node_t  loaded_list[$];
    node_t  deepest;
    cost_t  pending_lengths[$];
    int     errors;
    int     loads;
    int     queries;
    int     checked;

    function new();
      foreach (anc_row[n, l]) begin
        anc_row[n][l]  = '0;
        cost_row[n][l] = '0;
      end
      foreach (depth_of[n]) begin
        depth_of[n] = '0;
        loaded[n]   = 1'b0;
      end
      deepest = '0;
      errors  = 0;
      loads   = 0;
      queries = 0;
      checked = 0;
    endfunction

    // Fill the rows of a node from the rows of its parent.
    function void grow_rows(node_t nd, node_t par, weight_t wt);
      node_t mid;
      anc_row[nd][0]  = par;
      cost_row[nd][0] = (par == '0) ? '0 : cost_t'(wt);
      depth_of[nd]    = depth_of[par] + 1'b1;
      for (int i = 1; i < LIFT_LEVELS_DEF; i++) begin
        mid = anc_row[nd][i-1];
        anc_row[nd][i]  = anc_row[mid][i-1];
        cost_row[nd][i] = cost_row[mid][i-1] + cost_row[nd][i-1];
      end
      if (!loaded[nd]) begin
        loaded[nd] = 1'b1;
        loaded_list.insert(loaded_list.size(), nd);
      end
      if (depth_of[nd] >= depth_of[deepest]) deepest = nd;
    endfunction

    // Sum the edge weights between two nodes by binary lifting.
    function cost_t path_between(node_t a, node_t b);
      node_t  x;
      node_t  y;
      depth_t gap;
      cost_t  acc;
      x   = a;
      y   = b;
      acc = '0;
      if (depth_of[x] > depth_of[y]) {x, y} = {y, x};
      gap = depth_of[y] - depth_of[x];
      for (int j = 0; j < LIFT_LEVELS_DEF; j++) begin
        if (gap[j]) begin
          acc = acc + cost_row[y][j];
          y   = anc_row[y][j];
        end
      end
      if (x == y) return acc;
      for (int j = LIFT_LEVELS_DEF - 1; j >= 0 && x != y; j--) begin
        if (anc_row[x][j] != anc_row[y][j]) begin
          acc = acc + cost_row[x][j] + cost_row[y][j];
          x   = anc_row[x][j];
          y   = anc_row[y][j];
        end
      end
      acc = acc + cost_row[x][0] + cost_row[y][0];
      return acc;
    endfunction

    // Note one accepted input item.
    function void note_item(cmd_e cmd, node_t nd, node_t par, weight_t wt, node_t oth);
      if (cmd == CMD_QUERY) begin
        queries++;
        pending_lengths.insert(pending_lengths.size(), path_between(nd, oth));
      end else if (nd != '0) begin
        loads++;
        grow_rows(nd, par, wt);
      end
    endfunction

    // Check one accepted result against the oldest expected length.
    function void check_length(cost_t got);
      cost_t want;
      if (pending_lengths.size() == 0) begin
        errors++;
        $display("%0t: unexpected path_length %0d with nothing pending", $time, got);
        return;
      end
      want = pending_lengths.pop_front();
      checked++;
      if (got !== want) begin
        errors++;
        $display("%0t: path_length mismatch: expected %0d, actual %0d", $time, want, got);
      end
    endfunction
  endclass

  logic    clk_i         = 1'b0;
  logic    rst_ni        = 1'b0;
  logic    in_valid_i    = 1'b0;
  logic    in_stall_o;
  logic    cmd_i         = CMD_LOAD;
  node_t   node_i        = '0;
  node_t   parent_node_i = '0;
  weight_t edge_weight_i = '0;
  node_t   other_node_i  = '0;
  logic    out_valid_o;
  logic    out_stall_i   = 1'b0;
  cost_t   path_length_o;

  path_scoreboard sb;
  node_t          free_nodes[$];
  int             idle_pct  = 0;
  int             stall_pct = 0;

  tree_lca_weighted_distance dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .node_i        (node_i),
    .parent_node_i (parent_node_i),
    .edge_weight_i (edge_weight_i),
    .other_node_i  (other_node_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .path_length_o (path_length_o)
  );

  // Clock: period 4.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Stall the result channel at random.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Sample both channels at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        sb.note_item(cmd_e'(cmd_i), node_i, parent_node_i, edge_weight_i, other_node_i);
      if (out_valid_o && !out_stall_i) sb.check_length(path_length_o);
    end
  end

  // Present one item after a random gap and hold it until accepted.
  task automatic send_item(input cmd_e c, input node_t n, input node_t p, input weight_t w,
                           input node_t o);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    cmd_i         = c;
    node_i        = n;
    parent_node_i = p;
    edge_weight_i = w;
    other_node_i  = o;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  function automatic node_t pick_loaded();
    if (sb.loaded_list.size() == 0) return '0;
    return sb.loaded_list[$urandom_range(sb.loaded_list.size() - 1)];
  endfunction

  // Build one random load or query; queries only touch loaded nodes.
  task automatic send_random(input int query_pct);
    node_t   a;
    node_t   b;
    weight_t w;
    int      r;
    if (sb.loaded_list.size() < 2 || $urandom_range(99) >= query_pct) begin
      while (free_nodes.size() != 0 && sb.loaded[free_nodes[0]]) void'(free_nodes.pop_front());
      if ($urandom_range(99) < 2)
        a = '0;
      else if (free_nodes.size() != 0 && (sb.loaded_list.size() == 0 ||
               $urandom_range(99) < 85))
        a = free_nodes.pop_front();
      else
        a = pick_loaded();
      r = $urandom_range(99);
      if (r < 65)      b = sb.deepest;
      else if (r < 75) b = '0;
      else             b = pick_loaded();
      case ($urandom_range(9))
        0:       w = '0;
        1:       w = '1;
        default: w = weight_t'($urandom);
      endcase
      send_item(CMD_LOAD, a, b, w, node_t'($urandom));
    end else begin
      r = $urandom_range(99);
      a = pick_loaded();
      if (r < 30) begin
        b = a;
        a = sb.deepest;
      end else if (r < 38) begin
        b = a;
      end else if (r < 50) begin
        b = sb.anc_row[a][0];
        if (b == '0) b = pick_loaded();
      end else begin
        b = pick_loaded();
      end
      if ($urandom_range(1)) {a, b} = {b, a};
      send_item(CMD_QUERY, a, node_t'($urandom), weight_t'($urandom), b);
    end
  endtask

  // Timeout guard.
  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int    j;
    int    goal;
    node_t tmp;
    int    phase_idle  [4];
    int    phase_stall [4];
    int    phase_query [4];

    phase_idle  = '{0, 48, 0, 29};
    phase_stall = '{0, 0, 48, 29};
    phase_query = '{25, 40, 45, 55};

    sb = new();
    for (int n = 1; n < NODE_COUNT_DEF; n++) free_nodes.insert(free_nodes.size(), node_t'(n));
    for (int n = free_nodes.size() - 1; n > 0; n--) begin
      j             = $urandom_range(n);
      tmp           = free_nodes[n];
      free_nodes[n] = free_nodes[j];
      free_nodes[j] = tmp;
    end

    // Hold reset, then release it at a falling edge.
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: sentinel load, root edges, extremes, reload, cross-tree query.
    send_item(CMD_LOAD,  10'd0,    10'd0,    16'hFFFF, 10'd0);
    send_item(CMD_LOAD,  10'd1,    10'd0,    16'hFFFF, 10'd0);
    send_item(CMD_LOAD,  10'd1023, 10'd1,    16'hFFFF, 10'd0);
    send_item(CMD_LOAD,  10'd512,  10'd1023, 16'h0000, 10'd0);
    send_item(CMD_LOAD,  10'd2,    10'd512,  16'h0001, 10'd0);
    send_item(CMD_LOAD,  10'd3,    10'd1,    16'h8000, 10'd0);
    send_item(CMD_LOAD,  10'd5,    10'd0,    16'h1234, 10'd0);
    send_item(CMD_LOAD,  10'd6,    10'd5,    16'd100,  10'd0);
    send_item(CMD_QUERY, 10'd1,    10'd0,    16'h0000, 10'd1);
    send_item(CMD_QUERY, 10'd1023, 10'd1023, 16'hFFFF, 10'd1);
    send_item(CMD_QUERY, 10'd2,    10'd0,    16'h0000, 10'd3);
    send_item(CMD_QUERY, 10'd3,    10'd0,    16'h0000, 10'd2);
    send_item(CMD_QUERY, 10'd2,    10'd0,    16'h0000, 10'd1023);
    send_item(CMD_QUERY, 10'd6,    10'd0,    16'h0000, 10'd2);
    send_item(CMD_QUERY, 10'd1023, 10'd0,    16'h0000, 10'd1023);
    send_item(CMD_LOAD,  10'd1023, 10'd3,    16'hFFFF, 10'd0);
    send_item(CMD_QUERY, 10'd2,    10'd0,    16'h0000, 10'd1023);
    send_item(CMD_QUERY, 10'd512,  10'd0,    16'h0000, 10'd3);
    send_item(CMD_QUERY, 10'd1023, 10'd0,    16'h0000, 10'd6);

    // Random phases under different idle and stall mixes.
    for (int ph = 0; ph < 4; ph++) begin
      in_valid_i = 1'b0;
      while (sb.pending_lengths.size() != 0) @(negedge clk_i);
      idle_pct  = phase_idle[ph];
      stall_pct = phase_stall[ph];
      goal = sb.loads + sb.queries + 258;
      while (sb.loads + sb.queries < goal) send_random(phase_query[ph]);
    end

    // Drain the remaining results, then allow for late extras.
    in_valid_i = 1'b0;
    stall_pct  = 0;
    while (sb.pending_lengths.size() != 0) @(negedge clk_i);
    repeat (4 * LIFT_LEVELS_DEF + 20) @(negedge clk_i);
    if (sb.pending_lengths.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d path lengths never arrived", $time, sb.pending_lengths.size());
    end

    $display("Covered %0d node loads and %0d distance queries under four pressure mixes.",
             sb.loads, sb.queries);
    $display("Checked %0d path lengths; %0d nodes loaded, deepest depth %0d.",
             sb.checked, sb.loaded_list.size(), sb.depth_of[sb.deepest]);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/tlwd_pkg.sv
hdl/tlwd_ram.sv
hdl/tlwd_seq.sv
hdl/tree_lca_weighted_distance.sv
sim/tree_lca_weighted_distance_tb.sv
